@@ rtl/ppmfd_pkg.sv @@
// Package for the PPM frame decoder: configuration layout, interval class,
// register indexes, state encoding and reset constants.
// No dependencies.
package ppmfd_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  localparam logic [15:0] ABORT_BELOW_RST     = 16'd800;
  localparam logic [15:0] CHANNEL_FLOOR_RST   = 16'd900;
  localparam logic [15:0] CHANNEL_CEILING_RST = 16'd2200;
  localparam logic [16:0] SYNC_MIN_RST        = 17'd2500;
  localparam logic [16:0] SYNC_MAX_RST        = 17'd11000;
  localparam logic [3:0]  MIN_CHANNELS_RST    = 4'd6;

  localparam logic [16:0] CENTER_US     = 17'd1000;
  localparam logic [9:0]  VALUE_MAX     = 10'd1000;
  localparam logic [16:0] FULL_INTERVAL = 17'h10000;

  typedef enum logic [2:0] {
    CFG_ABORT_BELOW     = 3'd0,
    CFG_CHANNEL_FLOOR   = 3'd1,
    CFG_CHANNEL_CEILING = 3'd2,
    CFG_SYNC_MIN        = 3'd3,
    CFG_SYNC_MAX        = 3'd4,
    CFG_MIN_CHANNELS    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic [15:0] abort_below;
    logic [15:0] channel_floor;
    logic [15:0] channel_ceiling;
    logic [16:0] sync_min;
    logic [16:0] sync_max;
    logic [3:0]  min_channels;
  } cfg_t;

  typedef struct packed {
    logic       short_gap;
    logic       sync_gap;
    logic       pulse;
    logic       above_floor;
    logic [9:0] value;
  } interval_class_t;

endpackage

@@ rtl/ppmfd_classify.sv @@
// Interval classifier: wraps the capture difference and sorts the interval
// against the configured bounds; also scales a channel pulse.
// Depends on ppmfd_pkg.
module ppmfd_classify
  import ppmfd_pkg::*;
(
  input  logic [15:0]     stamp,
  input  logic [15:0]     prev_stamp,
  input  cfg_t            cfg,
  output interval_class_t cls
);

  logic [15:0] diff;
  logic [16:0] interval;
  logic [16:0] offset;

  assign diff     = stamp - prev_stamp;
  assign interval = (diff == 16'd0) ? FULL_INTERVAL : {1'b0, diff};
  assign offset   = interval - CENTER_US;

  always_comb begin
    cls.short_gap   = interval < {1'b0, cfg.abort_below};
    cls.sync_gap    = (interval >= cfg.sync_min) && (interval <= cfg.sync_max);
    cls.pulse       = interval < {1'b0, cfg.channel_ceiling};
    cls.above_floor = interval > {1'b0, cfg.channel_floor};
    if (interval <= CENTER_US) begin
      cls.value = 10'd0;
    end else if (offset >= {7'd0, VALUE_MAX}) begin
      cls.value = VALUE_MAX;
    end else begin
      cls.value = offset[9:0];
    end
  end

endmodule

@@ rtl/ppm_frame_decoder_core.sv @@
// PPM frame decoder top level: sync tracking, channel store memory and
// frame emission through a registered output stage.
// Depends on ppmfd_pkg and ppmfd_classify.
// Emission: an edge is taken while idle; an accepted frame is then read out one
//   channel at a time, a store read (ST_READ) then an output load (ST_LOAD) that
//   waits for a free output; input is held off until the last channel is loaded.
// Throughput: one edge per cycle when no frame is being emitted.
// Reset: registers to defaults, unsynced, channel index and previous count zero; store not cleared.
module ppm_frame_decoder_core
  import ppmfd_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] capture_stamp
  input  logic        s_tuser,   // [0] overcapture
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] channel_number, [12:3] channel_value,
                                 // [16:13] channel_total
  output logic        m_tlast
);

  localparam int IDXW = $clog2(MAX_CHANNELS + 1);
  localparam int AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CMPW = (IDXW > 4) ? IDXW : 4;

  cfg_t            cfg;
  interval_class_t cls;
  state_t          state, state_next;

  logic [15:0]     prev_stamp;
  logic            in_sync;
  logic [IDXW-1:0] ch_idx;
  logic [IDXW-1:0] prev_cnt;
  logic [IDXW-1:0] frame_cnt;
  logic [AW-1:0]   rd_idx;
  logic [9:0]      rd_data;
  logic [9:0]      store_mem [MAX_CHANNELS];

  logic accept;
  logic out_free;
  logic rd_en;
  logic load;
  logic last_ch;
  logic do_store;
  logic drop_sync;
  logic set_sync;
  logic take_frame;
  logic close_bad;
  logic [CMPW-1:0] num_ext;
  logic [CMPW-1:0] cnt_ext;

  ppmfd_classify u_classify (
    .stamp      (s_tdata),
    .prev_stamp (prev_stamp),
    .cfg        (cfg),
    .cls        (cls)
  );

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign num_ext  = CMPW'(rd_idx);
  assign cnt_ext  = CMPW'(frame_cnt);
  assign last_ch  = (num_ext + CMPW'(1)) == cnt_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.abort_below     <= ABORT_BELOW_RST;
      cfg.channel_floor   <= CHANNEL_FLOOR_RST;
      cfg.channel_ceiling <= CHANNEL_CEILING_RST;
      cfg.sync_min        <= SYNC_MIN_RST;
      cfg.sync_max        <= SYNC_MAX_RST;
      cfg.min_channels    <= MIN_CHANNELS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ABORT_BELOW:     cfg.abort_below     <= cfg_data[15:0];
        CFG_CHANNEL_FLOOR:   cfg.channel_floor   <= cfg_data[15:0];
        CFG_CHANNEL_CEILING: cfg.channel_ceiling <= cfg_data[15:0];
        CFG_SYNC_MIN:        cfg.sync_min        <= cfg_data;
        CFG_SYNC_MAX:        cfg.sync_max        <= cfg_data;
        CFG_MIN_CHANNELS:    cfg.min_channels    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    do_store   = 1'b0;
    drop_sync  = 1'b0;
    set_sync   = 1'b0;
    take_frame = 1'b0;
    close_bad  = 1'b0;
    if (s_tuser || cls.short_gap) begin
      drop_sync = 1'b1;
    end else if (!in_sync) begin
      set_sync = cls.sync_gap;
    end else if (cls.pulse) begin
      if ((ch_idx < IDXW'(MAX_CHANNELS)) && cls.above_floor) begin
        do_store = 1'b1;
      end else begin
        drop_sync = 1'b1;
      end
    end else if (cls.sync_gap && (CMPW'(ch_idx) >= CMPW'(cfg.min_channels))
                 && (prev_cnt == ch_idx)) begin
      take_frame = 1'b1;
    end else begin
      close_bad = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && take_frame && (ch_idx != '0)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          state_next = last_ch ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    load     = 1'b0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_READ: rd_en    = 1'b1;
      ST_LOAD: load     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev_stamp <= 16'd0;
      in_sync    <= 1'b0;
      ch_idx     <= '0;
      prev_cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        prev_stamp <= s_tdata;
        if (drop_sync) begin
          in_sync <= 1'b0;
        end
        if (set_sync) begin
          in_sync <= 1'b1;
          ch_idx  <= '0;
        end
        if (do_store) begin
          ch_idx <= ch_idx + IDXW'(1);
        end
        if (take_frame) begin
          ch_idx <= '0;
        end
        if (close_bad) begin
          prev_cnt <= ch_idx;
          in_sync  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take_frame) begin
      frame_cnt <= ch_idx;
      rd_idx    <= '0;
    end else if (load && !last_ch) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_store) begin
      store_mem[ch_idx[AW-1:0]] <= cls.value;
    end
    if (rd_en) begin
      rd_data <= store_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {7'd0, cnt_ext[3:0], rd_data, num_ext[2:0]};
      m_tlast <= last_ch;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    ch_idx <= IDXW'(MAX_CHANNELS))
    else $error("channel index beyond store depth");

  a_emit_synced: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_sync)
    else $error("frame emission while unsynced");

  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (num_ext < cnt_ext))
    else $error("store read beyond frame length");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (load && last_ch) |=> (state == ST_IDLE) && m_tvalid && m_tlast)
    else $error("final channel transfer not staged");

endmodule

@@ dv/ppm_frame_decoder_core_tb.sv @@
// Self-checking testbench for ppm_frame_decoder_core: drives capture edges over the
// input stream and checks every emitted channel against a built-in frame predictor.
// Depends on ppmfd_pkg and the ppm_frame_decoder_core RTL.
module ppm_frame_decoder_core_tb;
  import ppmfd_pkg::*;

  localparam int MAX_CH = 8;
  localparam int CENTER = 1000;
  localparam int FULL_SCALE = 1000;
  localparam int FULL_SPAN = 65536;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [2:0] number;
    logic [9:0] value;
    logic [3:0] total;
    logic       last;
  } channel_beat_t;

  class channel_scoreboard;
    logic [15:0] abort_lim = ABORT_BELOW_RST;
    logic [15:0] floor_lim = CHANNEL_FLOOR_RST;
    logic [15:0] ceil_lim = CHANNEL_CEILING_RST;
    logic [16:0] gap_lo = SYNC_MIN_RST;
    logic [16:0] gap_hi = SYNC_MAX_RST;
    logic [3:0]  need_channels = MIN_CHANNELS_RST;

    logic [15:0] last_stamp = '0;
    logic        locked = 1'b0;
    logic [3:0]  pulse_count = '0;
    logic [3:0]  held_count = '0;
    logic [9:0]  pulse_store [MAX_CH];

    channel_beat_t expected_channels [$];
    int errors = 0;
    int checked = 0;

    function void set_reg(logic [2:0] idx, logic [16:0] val);
      case (idx)
        CFG_ABORT_BELOW: abort_lim = val[15:0];
        CFG_CHANNEL_FLOOR: floor_lim = val[15:0];
        CFG_CHANNEL_CEILING: ceil_lim = val[15:0];
        CFG_SYNC_MIN: gap_lo = val;
        CFG_SYNC_MAX: gap_hi = val;
        CFG_MIN_CHANNELS: need_channels = val[3:0];
        default: ;
      endcase
    endfunction

    function bit is_gap(logic [16:0] span);
      return span >= gap_lo && span <= gap_hi;
    endfunction

    function logic [9:0] scale(logic [16:0] span);
      if (span <= CENTER) return '0;
      if (span - CENTER >= FULL_SCALE) return 10'(FULL_SCALE);
      return 10'(span - CENTER);
    endfunction

    function int pending();
      return expected_channels.size();
    endfunction

    function void note_edge(logic [15:0] stamp, logic over);
      logic [16:0] span;
      channel_beat_t beat;
      if (over) begin
        last_stamp = stamp;
        locked = 1'b0;
        return;
      end
      if (stamp > last_stamp) span = {1'b0, stamp} - {1'b0, last_stamp};
      else span = 17'h10000 - {1'b0, last_stamp} + {1'b0, stamp};
      last_stamp = stamp;
      if (span < {1'b0, abort_lim}) begin
        locked = 1'b0;
        return;
      end
      if (!locked) begin
        if (is_gap(span)) begin
          locked = 1'b1;
          pulse_count = '0;
        end
        return;
      end
      if (span < {1'b0, ceil_lim}) begin
        if (pulse_count < MAX_CH && span > {1'b0, floor_lim}) begin
          pulse_store[pulse_count[2:0]] = scale(span);
          pulse_count++;
        end else begin
          locked = 1'b0;
        end
        return;
      end
      if (is_gap(span) && pulse_count >= need_channels && held_count == pulse_count) begin
        for (int k = 0; k < int'(pulse_count); k++) begin
          beat.number = k[2:0];
          beat.value = pulse_store[k[2:0]];
          beat.total = pulse_count;
          beat.last = (k == int'(pulse_count) - 1);
          expected_channels.push_back(beat);
        end
        pulse_count = '0;
        return;
      end
      held_count = pulse_count;
      locked = 1'b0;
    endfunction

    function void check_channel(channel_beat_t got);
      channel_beat_t want;
      checked++;
      if (expected_channels.size() == 0) begin
        $error("unexpected channel transfer: number %0d value %0d total %0d last %0d",
               got.number, got.value, got.total, got.last);
        errors++;
        return;
      end
      want = expected_channels.pop_front();
      if (got.number != want.number) begin
        $error("channel_number: expected %0d, got %0d", want.number, got.number);
        errors++;
      end
      if (got.value != want.value) begin
        $error("channel_value: expected %0d, got %0d", want.value, got.value);
        errors++;
      end
      if (got.total != want.total) begin
        $error("channel_total: expected %0d, got %0d", want.total, got.total);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;

  channel_scoreboard sb = new();
  logic [15:0] cur_stamp = '0;
  int edges_sent = 0;
  int settings_applied = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold = 0;
  int quiet = 0;

  ppm_frame_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_channel(channel_beat_t'{m_tdata[2:0], m_tdata[12:3], m_tdata[16:13], m_tlast});
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("ppm_frame_decoder_core_tb: FAIL");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_SRC: begin
        src_idle_pct = 80;
        sink_stall_pct = 0;
      end
      IDLE_SINK: begin
        src_idle_pct = 0;
        sink_stall_pct = 80;
      end
      IDLE_BOTH: begin
        src_idle_pct = 30;
        sink_stall_pct = 30;
      end
      default: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_stamp(logic [15:0] stamp, logic over);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= stamp;
    s_tuser <= over;
    do @(posedge clk); while (!s_tready);
    sb.note_edge(stamp, over);
    cur_stamp = stamp;
    edges_sent++;
    @(negedge clk);
  endtask

  // a span of 65536 repeats the stamp
  task automatic send_span(int span, logic over);
    send_stamp(cur_stamp + span[15:0], over);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_cfg(int abort_v, int floor_v, int ceil_v, int gmin, int gmax, int need);
    write_reg(CFG_ABORT_BELOW, 17'(abort_v));
    write_reg(CFG_CHANNEL_FLOOR, 17'(floor_v));
    write_reg(CFG_CHANNEL_CEILING, 17'(ceil_v));
    write_reg(CFG_SYNC_MIN, 17'(gmin));
    write_reg(CFG_SYNC_MAX, 17'(gmax));
    write_reg(CFG_MIN_CHANNELS, 17'(need));
    write_reg(CFG_SPARE_A, 17'($urandom));
    write_reg(CFG_SPARE_B, 17'($urandom));
    cfg_wr_en <= 1'b0;
    settings_applied++;
  endtask

  function automatic void pulse_range(output int lo, output int hi);
    lo = int'(sb.floor_lim) + 1;
    if (int'(sb.abort_lim) > lo) lo = int'(sb.abort_lim);
    hi = int'(sb.ceil_lim) - 1;
  endfunction

  function automatic void gap_range(output int lo, output int hi);
    lo = int'(sb.gap_lo);
    if (int'(sb.ceil_lim) > lo) lo = int'(sb.ceil_lim);
    if (int'(sb.abort_lim) > lo) lo = int'(sb.abort_lim);
    if (lo < 1) lo = 1;
    hi = int'(sb.gap_hi);
    if (hi > FULL_SPAN) hi = FULL_SPAN;
  endfunction

  // bias toward the bounds and the clamp corners of the channel scale
  function automatic int pick_in(int lo, int hi);
    int v;
    case ($urandom_range(7, 0))
      0: v = lo;
      1: v = hi;
      2: v = CENTER;
      3: v = CENTER + 1;
      4: v = CENTER + FULL_SCALE - 1;
      5: v = CENTER + FULL_SCALE;
      default: v = $urandom_range(hi, lo);
    endcase
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  task automatic send_noise();
    case ($urandom_range(4, 0))
      0: send_stamp(16'($urandom), 1'b1);
      1: send_stamp(16'($urandom), 1'b0);
      2: send_stamp(cur_stamp, 1'b0);
      3: begin
        if (sb.abort_lim > 1) send_span($urandom_range(int'(sb.abort_lim) - 1, 1), 1'b0);
        else send_stamp(16'($urandom), 1'b0);
      end
      default: send_span($urandom_range(FULL_SPAN, 1), 1'b0);
    endcase
  endtask

  task automatic send_frame_run(int n, int frames);
    int plo, phi, glo, ghi;
    pulse_range(plo, phi);
    gap_range(glo, ghi);
    send_span(pick_in(glo, ghi), 1'b0);
    repeat (frames) begin
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(99, 0) < 4) send_noise();
        else send_span(pick_in(plo, phi), 1'b0);
      end
      send_span(pick_in(glo, ghi), 1'b0);
    end
  endtask

  task automatic random_traffic(int target);
    int plo, phi, glo, ghi, n, goal;
    goal = edges_sent + target;
    pulse_range(plo, phi);
    gap_range(glo, ghi);
    while (edges_sent < goal) begin
      if ($urandom_range(99, 0) < 75 && plo <= phi && glo <= ghi) begin
        if ($urandom_range(99, 0) < 80 && sb.need_channels <= MAX_CH)
          n = $urandom_range(MAX_CH, int'(sb.need_channels));
        else
          n = $urandom_range(MAX_CH + 1, 1);
        send_frame_run(n, $urandom_range(5, 2));
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    int first_pulses [6];
    int second_pulses [6];
    first_pulses = '{901, 1000, 1001, 2000, 2199, 1500};
    second_pulses = '{1200, 1800, 1000, 2199, 901, 1999};
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    set_idling(IDLE_NONE);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_stamp(16'h0000, 1'b0);
    send_stamp(16'hFFFF, 1'b1);
    send_span(2500, 1'b0);
    foreach (first_pulses[i]) send_span(first_pulses[i], 1'b0);
    send_span(11000, 1'b0);
    send_span(5000, 1'b0);
    foreach (second_pulses[i]) send_span(second_pulses[i], 1'b0);
    send_span(3000, 1'b0);
    send_span(900, 1'b0);
    send_span(2500, 1'b0);
    send_span(2200, 1'b0);
    send_span(2600, 1'b0);
    send_span(799, 1'b0);
    send_span(11001, 1'b0);
    send_stamp(16'h0000, 1'b1);
    random_traffic(30);

    drain();
    apply_cfg(0, 0, 65535, 65535, FULL_SPAN, 1);
    set_idling(IDLE_SRC);
    random_traffic(15);

    drain();
    apply_cfg(500, 950, 2050, 3000, 20000, 8);
    set_idling(IDLE_SINK);
    random_traffic(10);
    sink_hold = HOLD_CYCLES;
    send_frame_run(8, 4);
    random_traffic(10);

    drain();
    apply_cfg(65535, 65535, 0, 0, FULL_SPAN, 8);
    set_idling(IDLE_BOTH);
    random_traffic(10);

    drain();
    apply_cfg(800, 900, 2200, 6000, 4000, 4);
    set_idling(IDLE_NONE);
    repeat (3) begin
      send_span(5000, 1'b0);
      repeat (5) send_span(1500, 1'b0);
    end
    random_traffic(5);

    drain();
    apply_cfg($urandom_range(900, 0), $urandom_range(1100, 900), $urandom_range(2400, 2000),
              $urandom_range(3000, 2400), $urandom_range(FULL_SPAN, 3000), $urandom_range(8, 1));
    set_idling(IDLE_BOTH);
    random_traffic(25);

    drain();
    apply_cfg(int'(ABORT_BELOW_RST), int'(CHANNEL_FLOOR_RST), int'(CHANNEL_CEILING_RST),
              int'(SYNC_MIN_RST), int'(SYNC_MAX_RST), int'(MIN_CHANNELS_RST));
    set_idling(IDLE_SRC);
    random_traffic(10);
    drain();
    set_idling(IDLE_NONE);
    random_traffic(10);

    drain();
    $display("Drove %0d capture edges and checked %0d channel transfers over %0d settings,",
             edges_sent, sb.checked, settings_applied + 1);
    $display("covering edge cases, frame runs, noise, output hold-off and idle phases.");
    if (sb.errors == 0) begin
      $display("ppm_frame_decoder_core_tb: PASS");
    end else begin
      $display("ppm_frame_decoder_core_tb: FAIL");
    end
    $finish;
  end

endmodule
